// File: rtl/core/lfp_pkg.sv
// Package for the nine-byte range sensor frame parser.
// Holds the frame constants and the result type; no dependencies.
package lfp_pkg;

  // Header byte that opens every frame (sent twice).
  localparam logic [7:0] FRAME_HEAD = 8'h59;

  // Distance code that the sensor sends when it has no valid reading.
  localparam logic [15:0] DIST_INVALID = 16'hFFFF;

  // Width of the frame phase counter.
  localparam int unsigned PHASE_W = 4;

  // One parsed frame as it leaves the parser.
  typedef struct packed {
    logic [15:0] distance_cm;
    logic [15:0] signal_strength;
    logic [7:0]  range_mode;
    logic        checksum_ok;
    logic        distance_valid;
  } result_t;

endpackage

// File: rtl/core/lfp_if.sv
// Channel interfaces for the frame parser: the byte channel and the result channel.
// Depends on nothing but the valid/ready handshake convention.
interface lfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfp_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] distance_cm;
  logic [15:0] signal_strength;
  logic [7:0]  range_mode;
  logic        checksum_ok;
  logic        distance_valid;

  modport source (output valid, output distance_cm, output signal_strength,
                  output range_mode, output checksum_ok, output distance_valid,
                  input ready);
  modport sink   (input valid, input distance_cm, input signal_strength,
                  input range_mode, input checksum_ok, input distance_valid,
                  output ready);
endinterface

// File: rtl/core/lidar_frame_parser_top.sv
// Top level of the nine-byte range sensor frame parser.
// Depends on lfp_pkg, lfp_if, lfp_parse_core and lfp_out_reg.
//
// Usage: bytes from the sensor serial link enter on in_byte, one item per byte.
// Each frame is two 0x59 header bytes, distance (little endian), strength,
// mode, one spare byte and an 8-bit sum checksum. On the checksum byte one
// item leaves on out_result with the frame fields and the check flags; all
// other bytes produce nothing.
// cfg_wr_en/cfg_wr_data write the enable bit; while it is low every byte is
// dropped and the header hunt starts afresh once it is set again.
// A byte is registered at the input and processed from there; the result of a
// checksum byte is then loaded into the output register once that register
// can take it.
// Throughput: one byte per cycle unless a result finds the result register full.
// Reset (rst_n low, synchronous) disables the parser, empties both registers
// and returns the phase to the first header byte.
// When the receiver stalls, the output register holds its item; bytes keep
// flowing until a second result is due, at which point in_byte.ready drops.
module lidar_frame_parser_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  lfp_byte_if.sink     in_byte,
  lfp_result_if.source out_result
);

  logic             enable_r;
  logic             byte_valid_r;
  logic [7:0]       byte_r;
  logic             load_ok;
  logic             advance;
  logic             emit;
  lfp_pkg::result_t result;

  // Enable register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_wr_en) begin
      enable_r <= cfg_wr_data;
    end
  end

  // Input register: a byte moves on unless its result would find the result register full.
  assign advance       = byte_valid_r && (load_ok || !emit);
  assign in_byte.ready = !byte_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
    end else if (in_byte.ready) begin
      byte_valid_r <= in_byte.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_byte.valid && in_byte.ready) begin
      byte_r <= in_byte.rx_byte;
    end
  end

  // Frame state machine.
  lfp_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .enable  (enable_r),
    .step    (advance),
    .byte_in (byte_r),
    .emit    (emit),
    .result  (result)
  );

  // Result register.
  lfp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && emit),
    .load_data (result),
    .load_ok   (load_ok),
    .res       (out_result)
  );

endmodule

// File: rtl/core/lfp_parse_core.sv
// Frame state machine of the parser: phase, running sum and held frame fields.
// Depends on lfp_pkg for the frame constants and the result type.
module lfp_parse_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             enable,
  input  logic             step,
  input  logic [7:0]       byte_in,
  output logic             emit,
  output lfp_pkg::result_t result
);

  localparam logic [lfp_pkg::PHASE_W-1:0] PH_HEAD0  = 4'd0;
  localparam logic [lfp_pkg::PHASE_W-1:0] PH_HEAD1  = 4'd1;
  localparam logic [lfp_pkg::PHASE_W-1:0] PH_DIST_L = 4'd2;
  localparam logic [lfp_pkg::PHASE_W-1:0] PH_DIST_H = 4'd3;
  localparam logic [lfp_pkg::PHASE_W-1:0] PH_STR_L  = 4'd4;
  localparam logic [lfp_pkg::PHASE_W-1:0] PH_STR_H  = 4'd5;
  localparam logic [lfp_pkg::PHASE_W-1:0] PH_MODE   = 4'd6;
  localparam logic [lfp_pkg::PHASE_W-1:0] PH_SPARE  = 4'd7;
  localparam logic [lfp_pkg::PHASE_W-1:0] PH_CHECK  = 4'd8;

  logic [lfp_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [7:0]                  sum_r, sum_nxt;
  logic [15:0]                 dist_r, dist_nxt;
  logic [15:0]                 str_r, str_nxt;
  logic [7:0]                  mode_r, mode_nxt;
  logic                        sum_ok;

  // Next-state logic for one byte.
  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    dist_nxt  = dist_r;
    str_nxt   = str_r;
    mode_nxt  = mode_r;
    emit      = 1'b0;
    sum_ok    = (sum_r == byte_in);
    if (!enable) begin
      // A disabled parser drops the byte and restarts the header hunt.
      phase_nxt = PH_HEAD0;
    end else begin
      case (phase_r)
        PH_HEAD0: begin
          if (byte_in == lfp_pkg::FRAME_HEAD) begin
            sum_nxt   = byte_in;
            phase_nxt = PH_HEAD1;
          end
        end
        PH_HEAD1: begin
          if (byte_in == lfp_pkg::FRAME_HEAD) begin
            sum_nxt   = sum_r + byte_in;
            phase_nxt = PH_DIST_L;
          end else begin
            phase_nxt = PH_HEAD0;
          end
        end
        PH_DIST_L, PH_DIST_H, PH_STR_L, PH_STR_H, PH_MODE, PH_SPARE: begin
          // Payload bytes: capture the field and add to the sum.
          case (phase_r)
            PH_DIST_L: dist_nxt = {8'h00, byte_in};
            PH_DIST_H: dist_nxt = {byte_in, dist_r[7:0]};
            PH_STR_L:  str_nxt  = {8'h00, byte_in};
            PH_STR_H:  str_nxt  = {byte_in, str_r[7:0]};
            PH_MODE:   mode_nxt = byte_in;
            default:   mode_nxt = mode_r;
          endcase
          sum_nxt   = sum_r + byte_in;
          phase_nxt = phase_r + 4'd1;
        end
        PH_CHECK: begin
          emit      = 1'b1;
          phase_nxt = PH_HEAD0;
        end
        default: begin
          phase_nxt = PH_HEAD0;
        end
      endcase
    end
  end

  // Result fields as seen at the checksum byte.
  assign result.distance_cm     = dist_r;
  assign result.signal_strength = str_r;
  assign result.range_mode      = mode_r;
  assign result.checksum_ok     = sum_ok;
  assign result.distance_valid  = sum_ok && (dist_r != lfp_pkg::DIST_INVALID);

  // Phase is control state and is reset; the others are always written before use.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD0;
    end else if (step) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      sum_r  <= sum_nxt;
      dist_r <= dist_nxt;
      str_r  <= str_nxt;
      mode_r <= mode_nxt;
    end
  end

endmodule

// File: rtl/core/lfp_out_reg.sv
// Result register of the parser: holds one finished frame until the receiver takes it.
// Depends on lfp_pkg for the result type and lfp_if for the result channel.
module lfp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  lfp_pkg::result_t  load_data,
  output logic              load_ok,
  lfp_result_if.source      res
);

  logic             valid_r;
  lfp_pkg::result_t data_r;

  // The register can take a new item when empty or when its item leaves now.
  assign load_ok = !valid_r || res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (res.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign res.valid           = valid_r;
  assign res.distance_cm     = data_r.distance_cm;
  assign res.signal_strength = data_r.signal_strength;
  assign res.range_mode      = data_r.range_mode;
  assign res.checksum_ok     = data_r.checksum_ok;
  assign res.distance_valid  = data_r.distance_valid;

endmodule

// File: sim/lidar_frame_parser_top_test.sv
// Self-checking testbench for lidar_frame_parser_top: sends byte items, predicts each parsed frame
// and compares every result item field by field. Depends on lfp_pkg, lfp_if and the RTL.
module lidar_frame_parser_top_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES = 1700;
  localparam int SETTLE_CYCLES = 4;

  // Position of the predictor within a nine-byte frame.
  typedef enum logic [lfp_pkg::PHASE_W-1:0] {
    PH_HEAD1, PH_HEAD2, PH_DIST_LO, PH_DIST_HI, PH_STR_LO, PH_STR_HI,
    PH_MODE, PH_SPARE, PH_CHECK
  } frame_phase_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  lfp_byte_if   byte_ch ();
  lfp_result_if res_ch ();

  lidar_frame_parser_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_byte    (byte_ch.sink),
    .out_result (res_ch.source)
  );

  // Predictor state, a shadow of the parser.
  logic             parse_en;
  frame_phase_t     hunt_phase;
  logic [7:0]       byte_sum;
  logic [15:0]      dist_q;
  logic [15:0]      strength_q;
  logic [7:0]       mode_q;
  lfp_pkg::result_t pending_frames[$];

  // Stimulus bookkeeping.
  int   error_count;
  int   quiet_cycles;
  int   enabled_bytes;
  logic enable_setting;
  logic calm;

  // Free-running clock with a period of two time units.
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Works out the effect of one accepted byte on the parser and queues any frame it completes.
  task automatic advance_parser(input logic [7:0] b);
    lfp_pkg::result_t frame;
    logic             take;
    take = 1'b1;
    if (!parse_en) begin
      hunt_phase = PH_HEAD1;
      return;
    end
    case (hunt_phase)
      PH_HEAD1: begin
        take = 1'b0;
        if (b == lfp_pkg::FRAME_HEAD) begin
          byte_sum   = b;
          hunt_phase = PH_HEAD2;
        end
      end
      PH_HEAD2: begin
        take = 1'b0;
        if (b == lfp_pkg::FRAME_HEAD) begin
          byte_sum   = byte_sum + b;
          hunt_phase = PH_DIST_LO;
        end else begin
          hunt_phase = PH_HEAD1;
        end
      end
      PH_DIST_LO: dist_q = {8'h00, b};
      PH_DIST_HI: dist_q[15:8] = b;
      PH_STR_LO:  strength_q = {8'h00, b};
      PH_STR_HI:  strength_q[15:8] = b;
      PH_MODE:    mode_q = b;
      PH_SPARE:   ;
      PH_CHECK: begin
        take                  = 1'b0;
        frame.distance_cm     = dist_q;
        frame.signal_strength = strength_q;
        frame.range_mode      = mode_q;
        frame.checksum_ok     = (byte_sum == b);
        frame.distance_valid  = (byte_sum == b) && (dist_q != lfp_pkg::DIST_INVALID);
        pending_frames.push_back(frame);
        hunt_phase = PH_HEAD1;
      end
      default: begin
        take       = 1'b0;
        hunt_phase = PH_HEAD1;
      end
    endcase
    if (take) begin
      byte_sum   = byte_sum + b;
      hunt_phase = frame_phase_t'(hunt_phase + 1'b1);
    end
  endtask

  // Compares one received result item with the oldest predicted frame.
  task automatic check_frame();
    lfp_pkg::result_t want;
    if (pending_frames.size() == 0) begin
      $error("unexpected result item: distance_cm %0h", res_ch.distance_cm);
      error_count++;
      return;
    end
    want = pending_frames.pop_front();
    if (res_ch.distance_cm !== want.distance_cm) begin
      $error("distance_cm: expected %0h, got %0h", want.distance_cm, res_ch.distance_cm);
      error_count++;
    end
    if (res_ch.signal_strength !== want.signal_strength) begin
      $error("signal_strength: expected %0h, got %0h", want.signal_strength,
             res_ch.signal_strength);
      error_count++;
    end
    if (res_ch.range_mode !== want.range_mode) begin
      $error("range_mode: expected %0h, got %0h", want.range_mode, res_ch.range_mode);
      error_count++;
    end
    if (res_ch.checksum_ok !== want.checksum_ok) begin
      $error("checksum_ok: expected %0b, got %0b", want.checksum_ok, res_ch.checksum_ok);
      error_count++;
    end
    if (res_ch.distance_valid !== want.distance_valid) begin
      $error("distance_valid: expected %0b, got %0b", want.distance_valid,
             res_ch.distance_valid);
      error_count++;
    end
  endtask

  // Watches both channels and the register port at each rising edge; also the watchdog.
  always @(posedge clk) begin
    if (!rst_n) begin
      parse_en     = 1'b0;
      hunt_phase   = PH_HEAD1;
      byte_sum     = '0;
      dist_q       = '0;
      strength_q   = '0;
      mode_q       = '0;
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (res_ch.valid && res_ch.ready) begin
        check_frame();
        quiet_cycles = 0;
      end
      if (cfg_wr_en) begin
        parse_en     = cfg_wr_data;
        quiet_cycles = 0;
      end
      if (byte_ch.valid && byte_ch.ready) begin
        advance_parser(byte_ch.rx_byte);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // The receiver stalls at random except during a calm stretch.
  always @(negedge clk) begin
    res_ch.ready = calm || ($urandom_range(99) >= 28);
  end

  // Sends one byte item and returns at the falling edge after it was taken.
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(99) < 28) begin
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    byte_ch.valid   = 1'b1;
    byte_ch.rx_byte = b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    if (enable_setting) enabled_bytes++;
    @(negedge clk);
    byte_ch.valid = 1'b0;
  endtask

  // Sends bytes first..last of a frame built from the given fields.
  task automatic send_frame(input logic [15:0] dist_val, input logic [15:0] strength,
                            input logic [7:0] mode, input logic [7:0] spare,
                            input logic bad_sum, input int first, input int last);
    logic [7:0] frame_bytes[9];
    logic [7:0] total;
    frame_bytes = '{lfp_pkg::FRAME_HEAD, lfp_pkg::FRAME_HEAD, dist_val[7:0], dist_val[15:8],
                    strength[7:0], strength[15:8], mode, spare, 8'h00};
    total = '0;
    for (int i = 0; i < 8; i++) total = total + frame_bytes[i];
    frame_bytes[8] = bad_sum ? total ^ 8'($urandom_range(1, 255)) : total;
    for (int i = first; i <= last; i++) send_byte(frame_bytes[i]);
  endtask

  // Waits until every predicted frame has arrived and the pipeline has drained.
  task automatic wait_until_idle();
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes the enable register while nothing is in flight.
  task automatic set_enable(input logic value);
    wait_until_idle();
    cfg_wr_en      = 1'b1;
    cfg_wr_data    = value;
    enable_setting = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // A whole frame sent while the parser is off must give nothing.
  task automatic test_parser_disabled();
    set_enable(1'b0);
    send_frame(16'h1234, 16'h5678, 8'h02, 8'h00, 1'b0, 0, 8);
  endtask

  // Field extremes, the invalid distance code and a checksum mismatch.
  task automatic test_field_extremes();
    set_enable(1'b1);
    send_frame(lfp_pkg::DIST_INVALID, 16'h0000, 8'hFF, 8'h00, 1'b0, 0, 8);
    send_frame(16'h0000, 16'hFFFF, 8'h00, 8'hFF, 1'b1, 0, 8);
  endtask

  // Noise before a header, and a wrong second header byte that restarts the hunt.
  task automatic test_header_hunt();
    send_byte(8'h00);
    send_byte(lfp_pkg::FRAME_HEAD);
    send_byte(8'h58);
    send_frame(16'hFFFE, 16'h8001, 8'h07, 8'h5A, 1'b0, 0, 8);
  endtask

  // Toggling the enable mid-frame, with and without a byte dropped while off.
  task automatic test_enable_toggle();
    send_frame(16'h0102, 16'h0304, 8'h05, 8'h06, 1'b0, 0, 3);
    set_enable(1'b0);
    set_enable(1'b1);
    send_frame(16'h0102, 16'h0304, 8'h05, 8'h06, 1'b0, 4, 8);
    send_frame(16'hA55A, 16'h3CC3, 8'h80, 8'h01, 1'b0, 0, 4);
    set_enable(1'b0);
    send_byte(lfp_pkg::FRAME_HEAD);
    set_enable(1'b1);
    send_frame(16'hA55A, 16'h3CC3, 8'h80, 8'h01, 1'b0, 5, 8);
  endtask

  // Mostly well-formed frames with random content, mixed with noise and cut-off frames.
  task automatic test_random_traffic();
    int            start;
    int            pick;
    int            next_toggle;
    logic [15:0]   dist_val;
    logic [15:0]   strength;
    logic [7:0]    wrong;
    start       = enabled_bytes;
    next_toggle = start + 400;
    while (enabled_bytes - start < RANDOM_BYTES) begin
      calm = (enabled_bytes - start >= 600) && (enabled_bytes - start < 900);
      pick = $urandom_range(99);
      case ($urandom_range(9))
        0:       dist_val = lfp_pkg::DIST_INVALID;
        1:       dist_val = 16'h0000;
        default: dist_val = 16'($urandom);
      endcase
      case ($urandom_range(9))
        0:       strength = 16'hFFFF;
        1:       strength = 16'h0000;
        default: strength = 16'($urandom);
      endcase
      if (pick < 70) begin
        send_frame(dist_val, strength, 8'($urandom), 8'($urandom),
                   $urandom_range(99) < 15, 0, 8);
      end else if (pick < 80) begin
        send_frame(dist_val, strength, 8'($urandom), 8'($urandom), 1'b0, 0,
                   $urandom_range(1, 7));
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else if (pick < 94) begin
        wrong = 8'($urandom);
        if (wrong == lfp_pkg::FRAME_HEAD) wrong = ~wrong;
        send_byte(lfp_pkg::FRAME_HEAD);
        send_byte(wrong);
      end else begin
        send_byte(lfp_pkg::FRAME_HEAD);
      end
      // Now and then switch the parser off for a burst of bytes.
      if (enabled_bytes >= next_toggle) begin
        next_toggle = enabled_bytes + 400;
        calm        = 1'b0;
        set_enable(1'b0);
        send_frame(dist_val, strength, 8'($urandom), 8'($urandom), 1'b0, 0, 8);
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
        set_enable(1'b1);
      end
    end
    calm = 1'b0;
  endtask

  // Reset, the directed tests, the random traffic, then the verdict.
  initial begin
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = 1'b0;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = 8'h00;
    res_ch.ready    = 1'b0;
    error_count     = 0;
    quiet_cycles    = 0;
    enabled_bytes   = 0;
    enable_setting  = 1'b0;
    calm            = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_parser_disabled();
    test_field_extremes();
    test_header_hunt();
    test_enable_toggle();
    test_random_traffic();

    wait_until_idle();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/lfp_pkg.sv
rtl/core/lfp_if.sv
rtl/core/lfp_parse_core.sv
rtl/core/lfp_out_reg.sv
rtl/core/lidar_frame_parser_top.sv
sim/lidar_frame_parser_top_test.sv
